// ----- rtl/text_line_column_locator_assert.svh -----
// ----------------------------------------------------------------------------
// Text line column locator assertion macros
// Shared property forms for the locator checks, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_LINE_COLUMN_LOCATOR_ASSERT_SVH
`define TEXT_LINE_COLUMN_LOCATOR_ASSERT_SVH

// same-cycle implication
`define TLCL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlcl: same-cycle check failed");

// next-cycle implication
`define TLCL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlcl: next-cycle check failed");

`endif

// ----- rtl/tlcl_pkg.sv -----
// ----------------------------------------------------------------------------
// Text line column locator package
// Constants, codes, state type and control structs shared by the locator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tlcl_pkg;

  localparam int MAX_LINES_DEF = 4096;
  localparam int POS_BITS_DEF  = 20;

  localparam int KIND_W = 2;
  localparam int BYTE_W = 8;
  localparam int TABS_W = 8;
  localparam int TS_W   = 5;
  localparam int LINE_W = 12;
  localparam int COL_W  = 21;
  localparam int OUT_W  = ((LINE_W + COL_W + 1 + 7) / 8) * 8;

  localparam logic [KIND_W-1:0] KIND_BYTE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

  localparam logic [BYTE_W-1:0] TAB_CHAR     = 8'd9;
  localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'd10;
  localparam logic [TABS_W-1:0] TAB_COUNT_MAX = 8'd255;

  localparam logic [TS_W-1:0] TAB_WIDTH_RESET = 5'd4;
  localparam logic [TS_W-1:0] TAB_WIDTH_MIN   = 5'd1;
  localparam logic [TS_W-1:0] TAB_WIDTH_MAX   = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_CALC,
    ST_COL
  } tlcl_state_t;

  typedef struct packed {
    logic take;
    logic rd_sel_lo;
    logic cmp;
    logic calc;
    logic out_load;
  } tlcl_cmd_t;

  typedef struct packed {
    logic more;
  } tlcl_status_t;

endpackage

// ----- rtl/text_line_column_locator.sv -----
// ----------------------------------------------------------------------------
// Text line column locator
// Builds a table of line starts and leading-tab counts from a byte stream
// and answers position queries with line and tab-expanded column.
// ----------------------------------------------------------------------------
// Text bytes, restart items and unused kinds are taken at one item per
// cycle, back to back, while no query is in progress. A query holds off
// further input until it is done; its search makes k halving steps over
// the recorded lines (at most ceil(log2(lines)), at most 12 for a full
// 4096-line table): every search step is one read and one compare on
// the single read port of the line table RAM, followed by one read of the
// found line, an offset step and a column multiply step.
// The result sits in an output register, so the next item is taken while
// it waits; a further query stalls in its last cycle until that register
// is free. The table needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "text_line_column_locator_assert.svh"

module text_line_column_locator import tlcl_pkg::*; #(
  parameter int MAX_LINES = MAX_LINES_DEF,
  parameter int POS_BITS  = POS_BITS_DEF,
  localparam int IN_W = ((BYTE_W + POS_BITS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [TS_W-1:0]   cfg_wr_data,   // tab width
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,      // text_byte, query_pos, zero pad
  input  logic [KIND_W-1:0] in_tuser,      // kind
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata      // line_number, column_number, overflow, zero pad
);

  tlcl_cmd_t         cmd;
  tlcl_status_t      status;
  logic [LINE_W-1:0] line_num;
  logic [COL_W-1:0]  col_num;
  logic              ovf;

  tlcl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_kind    (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  tlcl_datapath #(
    .MAX_LINES (MAX_LINES),
    .POS_BITS  (POS_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_kind      (in_tuser),
    .in_text_byte (in_tdata[BYTE_W-1:0]),
    .in_query_pos (in_tdata[BYTE_W +: POS_BITS]),
    .cmd          (cmd),
    .status       (status),
    .out_line     (line_num),
    .out_col      (col_num),
    .out_ovf      (ovf)
  );

  assign out_tdata = {(OUT_W - LINE_W - COL_W - 1)'(0), ovf, col_num, line_num};

  `TLCL_ASSERT_NXT(a_query_holds_input, in_tvalid && in_tready && in_tuser == KIND_QUERY, !in_tready)
  `TLCL_ASSERT_IMP(a_no_result_overwrite, cmd.out_load, !out_tvalid || out_tready)
  `TLCL_ASSERT_IMP(a_calc_after_final_read, cmd.calc, $past(cmd.rd_sel_lo))
  `TLCL_ASSERT_IMP(a_valid_from_load, $rose(out_tvalid), $past(cmd.out_load))

endmodule

// ----- rtl/tlcl_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/tlcl_ctrl.sv -----
// ----------------------------------------------------------------------------
// Text line column locator controller
// Sequences item intake, the binary search over the line table, the
// column calculation and the output register load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlcl_ctrl import tlcl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic [KIND_W-1:0] in_kind,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  tlcl_status_t      status,
  output tlcl_cmd_t         cmd
);

  tlcl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_kind == KIND_QUERY) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = status.more ? ST_CMP : ST_CALC;
      end
      ST_CMP: begin
        state_nxt = ST_READ;
      end
      ST_CALC: begin
        state_nxt = ST_COL;
      end
      ST_COL: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.take  = in_tvalid;
      end
      ST_READ: begin
        cmd.rd_sel_lo = !status.more;
      end
      ST_CMP: begin
        cmd.cmp = 1'b1;
      end
      ST_CALC: begin
        cmd.calc = 1'b1;
      end
      ST_COL: begin
        cmd.out_load = out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ----- rtl/tlcl_datapath.sv -----
// ----------------------------------------------------------------------------
// Text line column locator datapath
// Line table, text scan counters, search bounds, column arithmetic and
// the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlcl_datapath import tlcl_pkg::*; #(
  parameter int MAX_LINES = MAX_LINES_DEF,
  parameter int POS_BITS  = POS_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [TS_W-1:0]     cfg_wr_data,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [BYTE_W-1:0]   in_text_byte,
  input  logic [POS_BITS-1:0] in_query_pos,
  input  tlcl_cmd_t           cmd,
  output tlcl_status_t        status,
  output logic [LINE_W-1:0]   out_line,
  output logic [COL_W-1:0]    out_col,
  output logic                out_ovf
);

  localparam int CNT_W  = $clog2(MAX_LINES + 1);
  localparam int IDX_W  = $clog2(MAX_LINES);
  localparam int ENT_W  = POS_BITS + TABS_W;
  localparam int PROD_W = POS_BITS + TS_W + 1;
  localparam int SUM_W  = (PROD_W > COL_W) ? PROD_W : COL_W;
  localparam int NTM_W  = TABS_W + TS_W;

  logic [TS_W-1:0]     tab_width_r, tab_width_nxt;
  logic [CNT_W-1:0]    lines_r, lines_nxt;
  logic [POS_BITS:0]   byte_off_r, byte_off_nxt;
  logic                lead_r, lead_nxt;
  logic [TABS_W-1:0]   cur_tabs_r, cur_tabs_nxt;
  logic [POS_BITS-1:0] cur_start_r, cur_start_nxt;
  logic                ovf_r, ovf_nxt;

  logic [POS_BITS-1:0] pos_r;
  logic [CNT_W-1:0]    lo_r, hi_r;
  logic                byp_r;
  logic [POS_BITS-1:0] n_r;
  logic [TABS_W-1:0]   nt_r;
  logic [LINE_W-1:0]   line_r;
  logic [COL_W-1:0]    col_r;
  logic                ovf_out_r;

  logic [CNT_W-1:0]    last;
  logic [CNT_W-1:0]    span;
  logic [CNT_W-1:0]    mid;
  logic [CNT_W-1:0]    rd_cnt;
  logic [ENT_W-1:0]    rd_data;
  logic [POS_BITS-1:0] ent_start;
  logic [TABS_W-1:0]   ent_tabs;
  logic [POS_BITS:0]   bo_inc;
  logic                take_byte;
  logic                take_restart;
  logic                take_query;
  logic                room;
  logic                nl_rec;

  logic [TS_W-1:0]     ts;
  logic [PROD_W-1:0]   prod;
  logic [NTM_W-1:0]    ntm;
  logic [SUM_W-1:0]    tail;
  logic [SUM_W-1:0]    col_full;
  logic [31:0]         lo_w;

  assign last   = lines_r - 1'b1;
  assign span   = hi_r - lo_r;
  assign mid    = lo_r + (span >> 1);
  assign rd_cnt = cmd.rd_sel_lo ? lo_r : mid;
  assign status.more = span > CNT_W'(1);

  assign take_byte    = cmd.take && in_kind == KIND_BYTE;
  assign take_restart = cmd.take && in_kind == KIND_RESTART;
  assign take_query   = cmd.take && in_kind == KIND_QUERY;

  assign bo_inc = byte_off_r + 1'b1;
  assign room   = (lines_r < CNT_W'(MAX_LINES)) && !bo_inc[POS_BITS];
  assign nl_rec = take_byte && in_text_byte == NEWLINE_CHAR && room;

  tlcl_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_LINES)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (nl_rec),
    .wr_addr (last[IDX_W-1:0]),
    .wr_data ({cur_tabs_r, cur_start_r}),
    .rd_addr (rd_cnt[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign ent_start = byp_r ? cur_start_r : rd_data[POS_BITS-1:0];
  assign ent_tabs  = byp_r ? cur_tabs_r  : rd_data[ENT_W-1:POS_BITS];

  always_comb begin
    tab_width_nxt = tab_width_r;
    lines_nxt     = lines_r;
    byte_off_nxt  = byte_off_r;
    lead_nxt      = lead_r;
    cur_tabs_nxt  = cur_tabs_r;
    cur_start_nxt = cur_start_r;
    ovf_nxt       = ovf_r;
    if (cfg_wr_en) begin
      tab_width_nxt = cfg_wr_data;
    end
    if (take_restart) begin
      lines_nxt     = CNT_W'(1);
      byte_off_nxt  = '0;
      lead_nxt      = 1'b1;
      cur_tabs_nxt  = '0;
      cur_start_nxt = '0;
      ovf_nxt       = 1'b0;
    end else if (take_byte) begin
      if (in_text_byte == NEWLINE_CHAR) begin
        if (room) begin
          lines_nxt     = lines_r + 1'b1;
          lead_nxt      = 1'b1;
          cur_tabs_nxt  = '0;
          cur_start_nxt = bo_inc[POS_BITS-1:0];
        end else begin
          ovf_nxt  = 1'b1;
          lead_nxt = 1'b0;
        end
      end else if (in_text_byte == TAB_CHAR && lead_r) begin
        if (cur_tabs_r < TAB_COUNT_MAX) begin
          cur_tabs_nxt = cur_tabs_r + 1'b1;
        end
      end else begin
        lead_nxt = 1'b0;
      end
      if (!byte_off_r[POS_BITS]) begin
        byte_off_nxt = bo_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_width_r <= TAB_WIDTH_RESET;
      lines_r     <= CNT_W'(1);
      byte_off_r  <= '0;
      lead_r      <= 1'b1;
      cur_tabs_r  <= '0;
      cur_start_r <= '0;
      ovf_r       <= 1'b0;
    end else begin
      tab_width_r <= tab_width_nxt;
      lines_r     <= lines_nxt;
      byte_off_r  <= byte_off_nxt;
      lead_r      <= lead_nxt;
      cur_tabs_r  <= cur_tabs_nxt;
      cur_start_r <= cur_start_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  always_comb begin
    if (tab_width_r < TAB_WIDTH_MIN) begin
      ts = TAB_WIDTH_MIN;
    end else if (tab_width_r > TAB_WIDTH_MAX) begin
      ts = TAB_WIDTH_MAX;
    end else begin
      ts = tab_width_r;
    end
  end

  assign prod = PROD_W'(n_r) * PROD_W'(ts);
  assign ntm  = NTM_W'(nt_r) * NTM_W'(ts - 1'b1);
  assign tail = SUM_W'(ntm) + SUM_W'(n_r);
  assign col_full = (SUM_W'(n_r) <= SUM_W'(nt_r)) ? SUM_W'(prod) : tail;
  assign lo_w = 32'(lo_r);

  always_ff @(posedge clk) begin
    byp_r <= (rd_cnt == last);
    if (take_query) begin
      pos_r <= in_query_pos;
      lo_r  <= '0;
      hi_r  <= lines_r;
    end else if (cmd.cmp) begin
      if (ent_start <= pos_r) begin
        lo_r <= mid;
      end else begin
        hi_r <= mid;
      end
    end
    if (cmd.calc) begin
      n_r  <= pos_r - ent_start;
      nt_r <= ent_tabs;
    end
    if (cmd.out_load) begin
      line_r    <= lo_w[LINE_W-1:0];
      col_r     <= col_full[COL_W-1:0];
      ovf_out_r <= ovf_r;
    end
  end

  assign out_line = line_r;
  assign out_col  = col_r;
  assign out_ovf  = ovf_out_r;

endmodule
